[src/crt_pkg.sv]
// Package for the two-moduli CRT solver: default width and sequencer states.
// No dependencies; imported by the solver top level.
`timescale 1ns / 1ps
`default_nettype none
package crt_pkg;

  localparam int MODULUS_BITS_DEF = 30;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_RED_A,
    S_RED_B,
    S_RED_AM,
    S_RED_N,
    S_EU_TEST,
    S_EU_DIV,
    S_EU_Q,
    S_EU_MUL,
    S_EU_UPD,
    S_DIFF,
    S_TMUL,
    S_XMUL,
    S_OUT
  } crt_state_t;

endpackage
`default_nettype wire

[src/crt_if.sv]
// Valid/ready channel interfaces for the CRT solver: input item and result.
// Depend on nothing; the width parameter follows the modulus width.
`timescale 1ns / 1ps
`default_nettype none
interface crt_in_if #(parameter int W = 30);
  logic         valid;
  logic         ready;
  logic [W-1:0] residue_a;
  logic [W-1:0] residue_b;
  logic [W-1:0] modulus_n;
  logic [W-1:0] modulus_m;
  modport source (output valid, residue_a, residue_b, modulus_n, modulus_m, input ready);
  modport sink (input valid, residue_a, residue_b, modulus_n, modulus_m, output ready);
endinterface

interface crt_out_if #(parameter int W = 30);
  logic           valid;
  logic           ready;
  logic [2*W-1:0] solution;
  logic           not_coprime;
  modport source (output valid, solution, not_coprime, input ready);
  modport sink (input valid, solution, not_coprime, output ready);
endinterface
`default_nettype wire

[src/crt_two_moduli_solver.sv]
// Sequence per item: check, four reductions, then per Euclid step a test, a divide, a
// quotient reduction, a modular product and an update; then the last test, difference,
// two products and output; a zero modulus or a gcd above one goes straight to output. A new item is
// taken only in idle, after the result is loaded, since the single bit-serial divide/multiply unit
// serves one item and a held result stalls the output. Reset (synchronous, active high) returns the
// sequencer to idle and drops any result. Depends on crt_pkg and the channel interfaces in crt_if.sv.
`timescale 1ns / 1ps
`default_nettype none
module crt_two_moduli_solver
  import crt_pkg::*;
#(
  parameter int MODULUS_BITS = MODULUS_BITS_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst,
  crt_in_if.sink     item,
  crt_out_if.source  result
);

  localparam int W  = MODULUS_BITS;
  localparam int CW = $clog2(W);
  localparam logic [CW-1:0] LAST = CW'(W - 1);

  crt_state_t state, state_next;

  // operands and Euclid state
  logic [W-1:0] ra, rb, rn, rm, ram, r0, r1, s0, s1, inv, qv;
  logic [2*W-1:0] sol;
  logic           err;

  // shared bit-serial unit
  logic [W-1:0]   ux, uy, um;
  logic [2*W-1:0] uacc;
  logic [CW-1:0]  cnt;
  logic           last;

  logic [W:0]     rem_sh, rem_sub;
  logic           div_ge;
  logic [W-1:0]   rem_new, quo_new;
  logic [W:0]     dbl, add;
  logic [W-1:0]   dbl_r, mm_new;
  logic [2*W-1:0] mul_new;
  logic [W-1:0]   qr, sn, diff;
  logic [W:0]     diff_w, sn_w;

  logic           ovalid;
  logic [2*W-1:0] osol;
  logic           oerr;

  assign last = (cnt == LAST);

  // restoring divide step: remainder in uacc, dividend/quotient shifts through uy
  always_comb begin
    rem_sh  = {uacc[W-1:0], uy[W-1]};
    rem_sub = rem_sh - {1'b0, um};
    div_ge  = (rem_sh >= {1'b0, um});
    rem_new = div_ge ? rem_sub[W-1:0] : rem_sh[W-1:0];
    quo_new = {uy[W-2:0], div_ge};
  end

  // modular double-and-add step, multiplier bits from uy MSB first
  always_comb begin
    dbl   = {uacc[W-1:0], 1'b0};
    dbl_r = (dbl >= {1'b0, um}) ? W'(dbl - {1'b0, um}) : dbl[W-1:0];
    add   = {1'b0, dbl_r} + {1'b0, ux};
    if (uy[W-1]) begin
      mm_new = (add >= {1'b0, um}) ? W'(add - {1'b0, um}) : add[W-1:0];
    end else begin
      mm_new = dbl_r;
    end
  end

  // plain shift-add product step
  assign mul_new = {uacc[2*W-2:0], 1'b0} + (uy[W-1] ? {{W{1'b0}}, ux} : '0);

  // small helpers for Euclid and the difference
  always_comb begin
    qr     = (qv >= rm) ? W'(qv - rm) : qv;
    sn_w   = {1'b0, s0} + {1'b0, rm} - {1'b0, qv};
    sn     = (s0 >= qv) ? W'(s0 - qv) : sn_w[W-1:0];
    diff_w = {1'b0, rb} + {1'b0, rm} - {1'b0, ram};
    diff   = (rb >= ram) ? W'(rb - ram) : diff_w[W-1:0];
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:    if (item.valid) state_next = S_CHECK;
      S_CHECK:   state_next = (rn == '0 || rm == '0) ? S_OUT : S_RED_A;
      S_RED_A:   if (last) state_next = S_RED_B;
      S_RED_B:   if (last) state_next = S_RED_AM;
      S_RED_AM:  if (last) state_next = S_RED_N;
      S_RED_N:   if (last) state_next = S_EU_TEST;
      S_EU_TEST: begin
        if (r1 != '0) state_next = S_EU_DIV;
        else if (r0 == W'(1)) state_next = S_DIFF;
        else state_next = S_OUT;
      end
      S_EU_DIV:  if (last) state_next = S_EU_Q;
      S_EU_Q:    state_next = S_EU_MUL;
      S_EU_MUL:  if (last) state_next = S_EU_UPD;
      S_EU_UPD:  state_next = S_EU_TEST;
      S_DIFF:    state_next = S_TMUL;
      S_TMUL:    if (last) state_next = S_XMUL;
      S_XMUL:    if (last) state_next = S_OUT;
      S_OUT:     if (!ovalid || result.ready) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // datapath: capture operands, run the unit, chain operations
  always_ff @(posedge clk) begin
    cnt <= cnt + CW'(1);
    case (state)
      S_IDLE: begin
        ra  <= item.residue_a;
        rb  <= item.residue_b;
        rn  <= item.modulus_n;
        rm  <= item.modulus_m;
        sol <= '0;
        err <= 1'b0;
      end
      S_CHECK: begin
        err  <= (rn == '0 || rm == '0);
        uy   <= ra;
        um   <= rn;
        uacc <= '0;
        cnt  <= '0;
      end
      S_RED_A, S_RED_B, S_RED_AM, S_RED_N, S_EU_DIV: begin
        uacc <= {{W{1'b0}}, rem_new};
        uy   <= quo_new;
        if (last) begin
          uacc <= '0;
          cnt  <= '0;
          case (state)
            S_RED_A: begin
              ra <= rem_new;
              uy <= rb;
              um <= rm;
            end
            S_RED_B: begin
              rb <= rem_new;
              uy <= ra;
              um <= rm;
            end
            S_RED_AM: begin
              ram <= rem_new;
              uy  <= rn;
              um  <= rm;
            end
            S_RED_N: begin
              r0 <= rm;
              r1 <= rem_new;
              s0 <= '0;
              s1 <= (rm == W'(1)) ? '0 : W'(1);
            end
            default: begin
              r0 <= r1;
              r1 <= rem_new;
              qv <= quo_new;
            end
          endcase
        end
      end
      S_EU_TEST: begin
        uy   <= r0;
        um   <= r1;
        uacc <= '0;
        cnt  <= '0;
        inv  <= s0;
        if (r1 == '0 && r0 != W'(1)) err <= 1'b1;
      end
      S_EU_Q: begin
        ux   <= s1;
        uy   <= qr;
        um   <= rm;
        uacc <= '0;
        cnt  <= '0;
      end
      S_EU_MUL, S_TMUL: begin
        uacc <= {{W{1'b0}}, mm_new};
        uy   <= {uy[W-2:0], 1'b0};
        if (last) begin
          qv <= mm_new;
          if (state == S_TMUL) begin
            ux   <= rn;
            uy   <= mm_new;
            uacc <= '0;
            cnt  <= '0;
          end
        end
      end
      S_EU_UPD: begin
        s0 <= s1;
        s1 <= sn;
      end
      S_DIFF: begin
        ux   <= diff;
        uy   <= inv;
        um   <= rm;
        uacc <= '0;
        cnt  <= '0;
      end
      S_XMUL: begin
        uacc <= mul_new;
        uy   <= {uy[W-2:0], 1'b0};
        if (last) sol <= mul_new + {{W{1'b0}}, ra};
      end
      default: begin
      end
    endcase
  end

  // output register: load on finish, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      ovalid <= 1'b0;
    end else if (state == S_OUT && (!ovalid || result.ready)) begin
      ovalid <= 1'b1;
    end else if (result.ready) begin
      ovalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!ovalid || result.ready)) begin
      osol <= err ? '0 : sol;
      oerr <= err;
    end
  end

  assign item.ready         = (state == S_IDLE);
  assign result.valid       = ovalid;
  assign result.solution    = osol;
  assign result.not_coprime = oerr;

  // an accepted item starts the check step
  a_start: assert property (@(posedge clk) disable iff (rst)
    item.valid && item.ready |=> state == S_CHECK)
    else $error("item transfer did not start the sequencer");

  // a flagged result carries zero
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.not_coprime |-> result.solution == '0)
    else $error("non-coprime result with nonzero solution");

  // Bezout coefficients stay reduced during Euclid
  a_coef: assert property (@(posedge clk) disable iff (rst)
    state == S_EU_TEST && rm > W'(1) |-> s0 < rm && s1 < rm)
    else $error("Euclid coefficient out of range");

endmodule
`default_nettype wire

[tb/tb_crt_two_moduli_solver.sv]
// Self-checking testbench for the two-moduli CRT solver: directed corner items, then
// random coprime and non-coprime moduli pairs, with random idling on both channels
// in all but one run. Depends on crt_pkg, crt_if.sv and crt_two_moduli_solver.sv.
`timescale 1ns / 1ps
module tb_crt_two_moduli_solver;
  import crt_pkg::*;

  localparam int W = 30;
  localparam int WATCHDOG_CYCLES = 200000;

  typedef struct packed {
    logic [2*W-1:0] solution;
    logic           not_coprime;
  } crt_answer_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  crt_in_if  #(.W(W)) item_ch ();
  crt_out_if #(.W(W)) result_ch ();

  crt_two_moduli_solver #(.MODULUS_BITS(W)) u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch.sink),
    .result (result_ch.source)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  crt_answer_t answers_due[$];
  int unsigned error_count = 0;
  int unsigned idle_cycles = 0;
  bit          sink_idle_on = 1'b1;
  bit          src_idle_on = 1'b1;
  bit          hold_off = 1'b0;

  // Inverse of val modulo md by extended Euclid; returns 1 when gcd is 1.
  function automatic bit modinv(input longint unsigned val, input longint unsigned md,
                                output longint unsigned inv);
    longint unsigned r0, r1, s0, s1, q, rn, sn;
    r0 = md; r1 = val; s0 = 0; s1 = 1 % md;
    while (r1 != 0) begin
      q = r0 / r1;
      rn = r0 - q * r1;
      sn = (s0 + md - ((q % md) * s1) % md) % md;
      r0 = r1; r1 = rn; s0 = s1; s1 = sn;
    end
    inv = s0;
    return r0 == 1;
  endfunction

  // Solve both congruences; the product diff*inv stays below 2^60.
  function automatic crt_answer_t crt_solve(input logic [W-1:0] ra, rb, mn, mm);
    crt_answer_t ans;
    longint unsigned n, m, a, b, inv, diff, t;
    ans.solution = '0;
    ans.not_coprime = 1'b1;
    n = mn; m = mm;
    if (n == 0 || m == 0) return ans;
    a = longint'(ra) % n;
    b = longint'(rb) % m;
    if (!modinv(n % m, m, inv)) return ans;
    diff = (b + m - (a % m)) % m;
    t = (diff * inv) % m;
    ans.solution = a + n * t;
    ans.not_coprime = 1'b0;
    return ans;
  endfunction

  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    $display("%0t mismatch %s: got %0d expected %0d", $time, what, got, want);
    error_count++;
  endtask

  // Offer one item and hold it until the transfer; predict its answer on acceptance.
  // Valid stays high after the transfer; drop it only while idling.
  task automatic send_item(input logic [W-1:0] ra, rb, mn, mm);
    while (src_idle_on && $urandom_range(99) < 28) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid     <= 1'b1;
    item_ch.residue_a <= ra;
    item_ch.residue_b <= rb;
    item_ch.modulus_n <= mn;
    item_ch.modulus_m <= mm;
    do @(posedge clk); while (!item_ch.ready);
    answers_due = {answers_due, crt_solve(ra, rb, mn, mm)};
  endtask

  // Receiver: random stalls, plus a long hold-off when requested.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= !hold_off && !(sink_idle_on && $urandom_range(99) < 28);
    end
  end

  // Check each transfer against the oldest predicted answer.
  always @(posedge clk) begin
    crt_answer_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (answers_due.size() == 0) begin
        report_mismatch("unexpected result", result_ch.solution, 0);
      end else begin
        want = answers_due.pop_front();
        if (result_ch.solution !== want.solution)
          report_mismatch("solution", result_ch.solution, want.solution);
        if (result_ch.not_coprime !== want.not_coprime)
          report_mismatch("not_coprime", result_ch.not_coprime, want.not_coprime);
      end
    end
  end

  // Watchdog on cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WATCHDOG_CYCLES) begin
      $display("tb_crt_two_moduli_solver: errors");
      $finish;
    end
  end

  function automatic logic [W-1:0] rand_word();
    return W'($urandom);
  endfunction

  // Half of the moduli small so Euclid runs are short; residues often reduced already.
  function automatic logic [W-1:0] rand_modulus();
    case ($urandom_range(3))
      0: return W'($urandom_range(2, 255));
      1: return W'($urandom_range(2, 65535));
      2: return rand_word() | 1;
      default: return rand_word();
    endcase
  endfunction

  task automatic test_directed();
    logic [W-1:0] top;
    top = '1;
    send_item(2, 3, 3, 5);
    send_item(0, 0, 1, 1);
    send_item(top, top, top, top - 1);
    send_item(top, 0, top, 1);
    send_item(0, top, 1, top);
    send_item(7, 9, 4, 6);
    send_item(1, 1, 0, 7);
    send_item(1, 1, 7, 0);
    send_item(0, 0, 0, 0);
    send_item(top, top, 3, 5);
    send_item(100, 200, 17, 19);
    send_item(top - 1, top - 2, top, top - 2);
    send_item(30'h2AAAAAAA, 30'h15555555, 30'h3FFFFFFB, 30'h3FFFFFDF);
    send_item(5, 6, 1, 2);
    send_item(1, 0, 2, 1);
    send_item(12, 34, 30'h20000000, 30'h1FFFFFFF);
  endtask

  task automatic test_random(input int count);
    logic [W-1:0] mn, mm, ra, rb;
    int f;
    for (int i = 0; i < count; i++) begin
      mn = rand_modulus();
      mm = rand_modulus();
      if ($urandom_range(9) == 0) begin
        f = $urandom_range(2, 30);
        mn = W'(f * $urandom_range(1, 1000));
        mm = W'(f * $urandom_range(1, 1000));
      end
      if ($urandom_range(3) == 0) begin
        ra = rand_word(); rb = rand_word();
      end else begin
        ra = (mn == 0) ? rand_word() : W'(rand_word() % mn);
        rb = (mm == 0) ? rand_word() : W'(rand_word() % mm);
      end
      send_item(ra, rb, mn, mm);
    end
  endtask

  task automatic test_backpressure();
    fork
      begin
        hold_off = 1'b1;
        repeat (20000) @(posedge clk);
        hold_off = 1'b0;
      end
      begin
        test_random(6);
        item_ch.valid <= 1'b0;
      end
    join
    @(posedge clk);
  endtask

  initial begin
    item_ch.valid <= 1'b0;
    item_ch.residue_a <= '0;
    item_ch.residue_b <= '0;
    item_ch.modulus_n <= '0;
    item_ch.modulus_m <= '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    src_idle_on = 1'b0;
    sink_idle_on = 1'b0;
    test_random(150);
    src_idle_on = 1'b1;
    sink_idle_on = 1'b1;
    test_random(880);
    item_ch.valid <= 1'b0;
    while (answers_due.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (error_count == 0)
      $display("tb_crt_two_moduli_solver: clean");
    else
      $display("tb_crt_two_moduli_solver: errors");
    $finish;
  end

endmodule

[files.f]
src/crt_pkg.sv
src/crt_if.sv
src/crt_two_moduli_solver.sv
tb/tb_crt_two_moduli_solver.sv
